// ===== src/cikc_pkg.sv =====
package cikc_pkg;

    // Word limit and keyword set size
    localparam int MAX_LEN       = 63;
    localparam int KEYWORD_COUNT = 37;

    localparam int KW_TABLE_SIZE = 37;
    localparam int KW_SLOT       = 11;
    localparam int KW_USED       = (KEYWORD_COUNT < KW_TABLE_SIZE) ? KEYWORD_COUNT
                                                                  : KW_TABLE_SIZE;
    localparam int KW_POS_W      = $clog2(KW_SLOT);

    // Counter widths follow the word limit
    localparam int CNT_W         = $clog2(MAX_LEN + 1);
    localparam int LEN_OUT_W     = 6;
    localparam int LEN_OUT_MAX   = 63;
    localparam int SAT_W         = (CNT_W > LEN_OUT_W) ? CNT_W : LEN_OUT_W;

    // Word queue between front and back
    localparam int FQ_DEPTH      = 2;
    localparam int FQ_PTR_W      = $clog2(FQ_DEPTH);

    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_US  = 8'h5F;

    // Keywords, left-justified, zero padded to KW_SLOT bytes
    localparam logic [KW_SLOT*8-1:0] KW_TABLE [KW_TABLE_SIZE] = '{
        {"auto",       56'd0}, {"_Bool",      48'd0}, {"break",      48'd0},
        {"case",       56'd0}, {"char",       56'd0}, {"_Complex",   24'd0},
        {"const",      48'd0}, {"continue",   24'd0}, {"default",    32'd0},
        {"restrict",   24'd0}, {"do",         72'd0}, {"double",     40'd0},
        {"else",       56'd0}, {"enum",       56'd0}, {"extern",     40'd0},
        {"float",      48'd0}, {"for",        64'd0}, {"goto",       56'd0},
        {"if",         72'd0}, {"_Imaginary",  8'd0}, {"inline",     40'd0},
        {"int",        64'd0}, {"long",       56'd0}, {"register",   24'd0},
        {"return",     40'd0}, {"short",      48'd0}, {"signed",     40'd0},
        {"sizeof",     40'd0}, {"static",     40'd0}, {"struct",     40'd0},
        {"switch",     40'd0}, {"typedef",    32'd0}, {"union",      48'd0},
        {"unsigned",   24'd0}, {"void",       56'd0}, {"volatile",   24'd0},
        {"while",      48'd0}
    };

    // One finished word on its way from front to back
    typedef struct packed {
        logic                syntax_ok;
        logic [KW_USED-1:0]  alive;
        logic [CNT_W-1:0]    len;
    } t_word;

    function automatic logic [7:0] kw_char(input int k, input logic [KW_POS_W-1:0] p);
        logic [7:0] c;
        c = 8'd0;
        if (int'(p) < KW_SLOT) begin
            c = KW_TABLE[k][(KW_SLOT - 1 - int'(p))*8 +: 8];
        end
        return c;
    endfunction

    function automatic int kw_len(input int k);
        int n;
        n = 0;
        for (int j = 0; j < KW_SLOT; j++) begin
            if (KW_TABLE[k][(KW_SLOT - 1 - j)*8 +: 8] != 8'd0) begin
                n = n + 1;
            end
        end
        return n;
    endfunction

endpackage

// ===== src/c_identifier_keyword_check_core.sv =====
// C identifier and keyword checker. Push one character byte per transaction on
// i_ch; a newline closes the current word, and so does the MAX_LEN-th character
// (the newline is not part of the word; one right after a full word closes an
// empty word). Each closed word gives exactly one result transaction:
// o_is_keyword is set when the word equals one of the 37 C99 keywords,
// o_is_identifier when it starts with a letter or underscore, goes on with
// letters, digits or underscores and is not a keyword, and o_word_length counts
// the characters before the first NUL byte (later bytes still count towards the
// limit but are not classified; bytes from 128 up are never letters or digits).
// The block takes one character every clock cycle while full is low. A result
// reaches the output ports by way of the word queue and the output register: the
// front stage narrows a keyword mask per character and posts finished words to
// a two-entry queue, and the back stage resolves the keyword length match into
// the output register. full rises only when that queue is full, which happens
// when results are not popped and two further words have closed behind the
// one on display.
module c_identifier_keyword_check_core import cikc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [7:0]           i_ch,
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic                 o_is_identifier,
    output logic                 o_is_keyword,
    output logic [LEN_OUT_W-1:0] o_word_length
);

    logic  w_q_push;
    t_word w_q_word_in;
    logic  w_q_full;
    logic  w_q_pop;
    logic  w_q_valid;
    t_word w_q_word_out;

    // Front: accept characters, track syntax and the surviving keyword mask
    cikc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .i_ch     (i_ch),
        .i_q_full (w_q_full),
        .o_q_push (w_q_push),
        .o_q_word (w_q_word_in)
    );

    // Hold finished words until the back stage is free
    cikc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_word  (w_q_word_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_word  (w_q_word_out)
    );

    // Back: resolve the keyword match and drive the result register
    cikc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_q_word        (w_q_word_out),
        .o_q_pop         (w_q_pop),
        .i_pop           (i_pop),
        .o_empty         (o_empty),
        .o_is_identifier (o_is_identifier),
        .o_is_keyword    (o_is_keyword),
        .o_word_length   (o_word_length)
    );

    // Stall the input whenever the word queue cannot take another word
    assign o_full = w_q_full;

    // A newline transaction always closes a word into the queue
    a_nl_closes_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full && (i_ch == CH_NL)) |-> w_q_push)
        else $error("newline did not close a word");

    // Never post a word into a full queue
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> !w_q_full)
        else $error("word posted to full queue");

    // A keyword is never also reported as an identifier
    a_kw_not_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> !(o_is_identifier && o_is_keyword))
        else $error("result flagged both identifier and keyword");

    // An identifier always has characters in it
    a_id_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_is_identifier) |-> (o_word_length != '0))
        else $error("empty word flagged as identifier");

endmodule

// ===== src/cikc_front.sv =====
module cikc_front import cikc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [7:0]  i_ch,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_word       o_q_word
);

    logic [CNT_W-1:0]   r_cnt,  n_cnt;
    logic               r_synt, n_synt;
    logic [KW_USED-1:0] r_mask, n_mask;
    logic               r_nul,  n_nul;
    logic [CNT_W-1:0]   r_clen, n_clen;

    logic               w_accept;
    logic               w_in_slot;
    logic               w_letter;
    logic               w_digit;
    logic               w_legal;
    logic [KW_USED-1:0] w_keep;

    assign w_accept  = i_push & ~i_q_full;
    assign w_in_slot = (r_clen < CNT_W'(KW_SLOT));
    assign w_letter  = ((i_ch >= "a") && (i_ch <= "z")) || ((i_ch >= "A") && (i_ch <= "Z"));
    assign w_digit   = (i_ch >= "0") && (i_ch <= "9");
    assign w_legal   = (i_ch == CH_US) || w_letter || ((r_clen != '0) && w_digit);

    // Narrow the keyword mask: compare each keyword's byte at the current position
    always_comb begin
        for (int k = 0; k < KW_USED; k++) begin
            w_keep[k] = w_in_slot && (kw_char(k, r_clen[KW_POS_W-1:0]) == i_ch);
        end
    end

    always_comb begin
        n_cnt    = r_cnt;
        n_synt   = r_synt;
        n_mask   = r_mask;
        n_nul    = r_nul;
        n_clen   = r_clen;
        o_q_push = 1'b0;
        o_q_word = '{syntax_ok: r_synt, alive: r_mask, len: r_clen};
        if (w_accept) begin
            if (i_ch == CH_NL) begin
                o_q_push = 1'b1;
                n_cnt    = '0;
                n_synt   = 1'b1;
                n_mask   = '1;
                n_nul    = 1'b0;
                n_clen   = '0;
            end else begin
                n_cnt = r_cnt + CNT_W'(1);
                if (!r_nul) begin
                    if (i_ch == CH_NUL) begin
                        n_nul = 1'b1;
                    end else begin
                        n_synt = r_synt & w_legal;
                        n_mask = r_mask & w_keep;
                        n_clen = r_clen + CNT_W'(1);
                    end
                end
                // Word full: close it with this character included
                if (n_cnt >= CNT_W'(MAX_LEN)) begin
                    o_q_push = 1'b1;
                    o_q_word = '{syntax_ok: n_synt, alive: n_mask, len: n_clen};
                    n_cnt    = '0;
                    n_synt   = 1'b1;
                    n_mask   = '1;
                    n_nul    = 1'b0;
                    n_clen   = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_synt <= 1'b1;
            r_mask <= '1;
            r_nul  <= 1'b0;
            r_clen <= '0;
        end else begin
            r_cnt  <= n_cnt;
            r_synt <= n_synt;
            r_mask <= n_mask;
            r_nul  <= n_nul;
            r_clen <= n_clen;
        end
    end

endmodule

// ===== src/cikc_fifo.sv =====
module cikc_fifo import cikc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_word i_word,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_word o_word
);

    t_word               r_mem [FQ_DEPTH];
    logic [FQ_PTR_W-1:0] r_wr;
    logic [FQ_PTR_W-1:0] r_rd;
    logic [FQ_PTR_W:0]   r_cnt;
    logic                w_wr_en;
    logic                w_rd_en;

    assign o_full  = (r_cnt == (FQ_PTR_W+1)'(FQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_word  = r_mem[r_rd];
    assign w_wr_en = i_push & ~o_full;
    assign w_rd_en = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr_en) begin
                r_wr <= r_wr + FQ_PTR_W'(1);
            end
            if (w_rd_en) begin
                r_rd <= r_rd + FQ_PTR_W'(1);
            end
            case ({w_wr_en, w_rd_en})
                2'b10:   r_cnt <= r_cnt + (FQ_PTR_W+1)'(1);
                2'b01:   r_cnt <= r_cnt - (FQ_PTR_W+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== src/cikc_back.sv =====
module cikc_back import cikc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  t_word                i_q_word,
    output logic                 o_q_pop,
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic                 o_is_identifier,
    output logic                 o_is_keyword,
    output logic [LEN_OUT_W-1:0] o_word_length
);

    logic                 r_valid;
    logic                 r_is_id;
    logic                 r_is_kw;
    logic [LEN_OUT_W-1:0] r_len;

    logic [KW_USED-1:0]   w_len_match;
    logic                 w_kw;
    logic [SAT_W-1:0]     w_len_wide;
    logic [LEN_OUT_W-1:0] w_len_sat;
    logic                 w_load;

    // A keyword matches when its prefix survived and its length equals the word's
    always_comb begin
        for (int k = 0; k < KW_USED; k++) begin
            w_len_match[k] = (i_q_word.len == CNT_W'(kw_len(k)));
        end
    end

    assign w_kw       = |(i_q_word.alive & w_len_match);
    assign w_len_wide = SAT_W'(i_q_word.len);
    assign w_len_sat  = (w_len_wide > SAT_W'(LEN_OUT_MAX)) ? LEN_OUT_W'(LEN_OUT_MAX)
                                                          : w_len_wide[LEN_OUT_W-1:0];
    assign w_load     = i_q_valid & (~r_valid | i_pop);
    assign o_q_pop    = w_load;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_is_id <= (i_q_word.len != '0) & i_q_word.syntax_ok & ~w_kw;
            r_is_kw <= w_kw;
            r_len   <= w_len_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    assign o_empty         = ~r_valid;
    assign o_is_identifier = r_is_id;
    assign o_is_keyword    = r_is_kw;
    assign o_word_length   = r_len;

endmodule
